// ===== src/ptb_pkg.sv =====
package ptb_pkg;

  // Default sizes of the bank.
  localparam int unsigned PERIOD_SLOTS_DEF  = 8;
  localparam int unsigned TIMEOUT_SLOTS_DEF = 8;
  localparam int unsigned COUNT_WIDTH_DEF   = 16;

  // Fixed widths of the request and result fields.
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned CFG_ADDR_W = 1;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Action codes of a request.
  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PSTART = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PSTOP  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PCLEAR = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TSTART = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_TSTOP  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_PERIODS_IN_USE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUTS_IN_USE = 1'b1;

  localparam logic [CFG_W-1:0] IN_USE_RESET = 4'd8;

  // Classified operation handed to the back end.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_PSTART,
    OP_PSTOP,
    OP_PCLEAR,
    OP_TSTART,
    OP_TSTOP,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } back_state_e;

endpackage

// ===== src/ptb_ram.sv =====
module ptb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ptb_queue.sv =====
module ptb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ptb_pkg::cmd_t       data_i,
  input  logic                pop_i,
  output ptb_pkg::cmd_t       data_o,
  output ptb_pkg::q_status_t  status_o
);

  localparam int unsigned DEPTH = ptb_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  ptb_pkg::cmd_t   mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, wptr_d;
  logic [AW-1:0]   rptr_q, rptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + NW'(push_i) - NW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rptr_q];
  assign status_o.full  = (cnt_q == NW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

  // The front must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i)
    else $error("Push into a full command queue.");

  // The back must never pop an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("Pop from an empty command queue.");

endmodule

// ===== src/ptb_front.sv =====
module ptb_front #(
  parameter int unsigned PERIOD_SLOTS  = ptb_pkg::PERIOD_SLOTS_DEF,
  parameter int unsigned TIMEOUT_SLOTS = ptb_pkg::TIMEOUT_SLOTS_DEF,
  localparam int unsigned PCNT_W = $clog2(PERIOD_SLOTS + 1),
  localparam int unsigned TCNT_W = $clog2(TIMEOUT_SLOTS + 1)
) (
  input  logic                          start_i,
  input  logic [ptb_pkg::ACTION_W-1:0]  action_i,
  input  logic [ptb_pkg::SLOT_W-1:0]    slot_i,
  input  logic [ptb_pkg::VALUE_W-1:0]   count_value_i,
  input  logic [PCNT_W-1:0]             p_in_use_i,
  input  logic [TCNT_W-1:0]             t_in_use_i,
  input  ptb_pkg::q_status_t            status_i,
  output logic                          busy_o,
  output logic                          push_o,
  output ptb_pkg::cmd_t                 cmd_o
);

  logic p_ok;
  logic t_ok;

  // A request is taken whenever the queue has room.
  assign busy_o = status_i.full;
  assign push_o = start_i && !status_i.full;

  // Slot range checks against the in-use counts.
  assign p_ok = (slot_i < p_in_use_i);
  assign t_ok = (slot_i < t_in_use_i);

  // Classify the request; out-of-range and unknown requests become rejects.
  always_comb begin
    cmd_o.slot  = slot_i;
    cmd_o.value = count_value_i;
    unique case (action_i)
      ptb_pkg::ACT_TICK:   cmd_o.op = ptb_pkg::OP_TICK;
      ptb_pkg::ACT_PSTART: cmd_o.op = p_ok ? ptb_pkg::OP_PSTART : ptb_pkg::OP_REJECT;
      ptb_pkg::ACT_PSTOP:  cmd_o.op = p_ok ? ptb_pkg::OP_PSTOP : ptb_pkg::OP_REJECT;
      ptb_pkg::ACT_PCLEAR: cmd_o.op = p_ok ? ptb_pkg::OP_PCLEAR : ptb_pkg::OP_REJECT;
      ptb_pkg::ACT_TSTART: cmd_o.op = t_ok ? ptb_pkg::OP_TSTART : ptb_pkg::OP_REJECT;
      ptb_pkg::ACT_TSTOP:  cmd_o.op = t_ok ? ptb_pkg::OP_TSTOP : ptb_pkg::OP_REJECT;
      default:             cmd_o.op = ptb_pkg::OP_REJECT;
    endcase
  end

endmodule

// ===== src/ptb_back.sv =====
module ptb_back #(
  parameter int unsigned PERIOD_SLOTS  = ptb_pkg::PERIOD_SLOTS_DEF,
  parameter int unsigned TIMEOUT_SLOTS = ptb_pkg::TIMEOUT_SLOTS_DEF,
  parameter int unsigned COUNT_WIDTH   = ptb_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned PCNT_W = $clog2(PERIOD_SLOTS + 1),
  localparam int unsigned TCNT_W = $clog2(TIMEOUT_SLOTS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  ptb_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  input  logic [PCNT_W-1:0]            p_in_use_i,
  input  logic [TCNT_W-1:0]            t_in_use_i,
  output logic                         done_o,
  output logic                         accepted_o,
  output logic [ptb_pkg::MASK_W-1:0]   period_done_mask_o,
  output logic [ptb_pkg::MASK_W-1:0]   timeout_expired_mask_o
);

  localparam int unsigned P   = PERIOD_SLOTS;
  localparam int unsigned T   = TIMEOUT_SLOTS;
  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned SW  = (P > T) ? P : T;
  localparam int unsigned IW  = $clog2(SW + 1);
  localparam int unsigned SAW = (SW > 1) ? $clog2(SW) : 1;
  localparam int unsigned PAW = (P > 1) ? $clog2(P) : 1;
  localparam int unsigned TAW = (T > 1) ? $clog2(T) : 1;
  localparam int unsigned PX  = (P > ptb_pkg::MASK_W) ? P : ptb_pkg::MASK_W;
  localparam int unsigned TX  = (T > ptb_pkg::MASK_W) ? T : ptb_pkg::MASK_W;

  ptb_pkg::back_state_e state_q, state_d;

  logic [IW-1:0]   idx_q, idx_d;
  logic            proc_vld_q, proc_vld_d;
  logic [SAW-1:0]  proc_idx_q, proc_idx_d;
  logic [P-1:0]    act_q, act_d;
  logic [P-1:0]    pdone_q, pdone_d;
  logic [T-1:0]    tzero_q, tzero_d;
  logic            rep_q, rep_d;
  logic            rep_acc_q, rep_acc_d;

  logic                         res_vld_q;
  logic                         res_acc_q;
  logic [ptb_pkg::MASK_W-1:0]   pmask_q, tmask_q;
  logic [ptb_pkg::MASK_W-1:0]   pmask, tmask;

  logic            p_we, t_we;
  logic [PAW-1:0]  p_waddr, cmd_paddr;
  logic [TAW-1:0]  t_waddr, cmd_taddr;
  logic [2*CW-1:0] p_wdata, p_rdata;
  logic [CW-1:0]   t_wdata, t_rdata;
  logic [CW-1:0]   val, p_reload, p_dec, t_dec;
  logic [SW-1:0]   act_ext, tzero_ext;
  logic [PX-1:0]   pdone_ext;
  logic [TX-1:0]   tzero_mx;
  logic            p_slot_en, t_slot_en, sweep_last;

  // Counter storage: reload and count share one word per period slot.
  ptb_ram #(.WIDTH(2 * CW), .DEPTH(P)) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (idx_q[PAW-1:0]),
    .rdata_o (p_rdata)
  );

  ptb_ram #(.WIDTH(CW), .DEPTH(T)) u_timeout_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (idx_q[TAW-1:0]),
    .rdata_o (t_rdata)
  );

  // Command fields and sweep slot decode.
  assign val       = CW'(cmd_i.value);
  assign cmd_paddr = PAW'(cmd_i.slot);
  assign cmd_taddr = TAW'(cmd_i.slot);
  assign pop_o     = (state_q == ptb_pkg::ST_IDLE) && !q_empty_i;

  assign act_ext   = SW'(act_q);
  assign tzero_ext = SW'(tzero_q);
  assign p_reload  = p_rdata[2*CW-1:CW];
  assign p_dec     = p_rdata[CW-1:0] - 1'b1;
  assign t_dec     = t_rdata - 1'b1;

  assign p_slot_en = (proc_idx_q < P) && (proc_idx_q < p_in_use_i) && act_ext[proc_idx_q];
  assign t_slot_en = (proc_idx_q < T) && (proc_idx_q < t_in_use_i) && !tzero_ext[proc_idx_q];
  assign sweep_last = proc_vld_q && (proc_idx_q == SAW'(SW - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptb_pkg::ST_IDLE: begin
        if (pop_o && (cmd_i.op == ptb_pkg::OP_TICK)) begin
          state_d = ptb_pkg::ST_SWEEP;
        end
      end
      ptb_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_d = ptb_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Command execution and the tick sweep, one slot per cycle.
  always_comb begin
    idx_d      = idx_q;
    proc_vld_d = 1'b0;
    proc_idx_d = proc_idx_q;
    act_d      = act_q;
    pdone_d    = pdone_q;
    tzero_d    = tzero_q;
    rep_d      = 1'b0;
    rep_acc_d  = rep_acc_q;
    p_we       = 1'b0;
    p_waddr    = cmd_paddr;
    p_wdata    = {val, val};
    t_we       = 1'b0;
    t_waddr    = cmd_taddr;
    t_wdata    = val;
    unique case (state_q)
      ptb_pkg::ST_IDLE: begin
        idx_d = '0;
        if (pop_o) begin
          rep_d     = (cmd_i.op != ptb_pkg::OP_TICK);
          rep_acc_d = (cmd_i.op != ptb_pkg::OP_REJECT);
          unique case (cmd_i.op)
            ptb_pkg::OP_PSTART: begin
              p_we             = 1'b1;
              act_d[cmd_paddr]   = 1'b1;
              pdone_d[cmd_paddr] = 1'b0;
            end
            ptb_pkg::OP_PSTOP: begin
              act_d[cmd_paddr] = 1'b0;
            end
            ptb_pkg::OP_PCLEAR: begin
              pdone_d[cmd_paddr] = 1'b0;
            end
            ptb_pkg::OP_TSTART: begin
              t_we               = 1'b1;
              tzero_d[cmd_taddr] = (val == '0);
            end
            ptb_pkg::OP_TSTOP: begin
              tzero_d[cmd_taddr] = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ptb_pkg::ST_SWEEP: begin
        // Issue the read of the next slot.
        if (idx_q < SW) begin
          idx_d      = idx_q + 1'b1;
          proc_vld_d = 1'b1;
          proc_idx_d = idx_q[SAW-1:0];
        end
        // Update the slot whose words came back from the memories.
        if (proc_vld_q) begin
          p_waddr = proc_idx_q[PAW-1:0];
          t_waddr = proc_idx_q[TAW-1:0];
          if (p_slot_en) begin
            p_we = 1'b1;
            if (p_dec == '0) begin
              pdone_d[proc_idx_q[PAW-1:0]] = 1'b1;
              p_wdata = {p_reload, p_reload};
            end else begin
              p_wdata = {p_reload, p_dec};
            end
          end
          if (t_slot_en) begin
            t_we    = 1'b1;
            t_wdata = t_dec;
            if (t_dec == '0) begin
              tzero_d[proc_idx_q[TAW-1:0]] = 1'b1;
            end
          end
        end
        if (sweep_last) begin
          rep_d     = 1'b1;
          rep_acc_d = 1'b1;
        end
      end
    endcase
  end

  // Status masks over the in-use slots.
  assign pdone_ext = PX'(pdone_q);
  assign tzero_mx  = TX'(tzero_q);

  always_comb begin
    for (int i = 0; i < ptb_pkg::MASK_W; i++) begin
      pmask[i] = pdone_ext[i] && (p_in_use_i > i);
      tmask[i] = tzero_mx[i] && (t_in_use_i > i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ptb_pkg::ST_IDLE;
      idx_q      <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
      act_q      <= '0;
      pdone_q    <= '0;
      tzero_q    <= '1;
      rep_q      <= 1'b0;
      rep_acc_q  <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      proc_vld_q <= proc_vld_d;
      proc_idx_q <= proc_idx_d;
      act_q      <= act_d;
      pdone_q    <= pdone_d;
      tzero_q    <= tzero_d;
      rep_q      <= rep_d;
      rep_acc_q  <= rep_acc_d;
      res_vld_q  <= rep_q;
    end
  end

  // Result payload, registered from the settled state while a report is due.
  always_ff @(posedge clk_i) begin
    if (rep_q) begin
      res_acc_q <= rep_acc_q;
      pmask_q   <= pmask;
      tmask_q   <= tmask;
    end
  end

  assign done_o                 = res_vld_q;
  assign accepted_o             = res_acc_q;
  assign period_done_mask_o     = pmask_q;
  assign timeout_expired_mask_o = tmask_q;

  // The slot in the update stage is always the one read just before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_vld_q |-> (idx_q == IW'(proc_idx_q) + 1'b1))
    else $error("Sweep read and update stages are misaligned.");

  // No slot update is pending once the sweep has ended.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptb_pkg::ST_IDLE) |-> !proc_vld_q)
    else $error("Slot update pending outside a sweep.");

  // Every finished sweep produces a report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ptb_pkg::ST_SWEEP) |-> rep_q)
    else $error("Tick sweep ended without a result.");

endmodule

// ===== src/periodic_and_timeout_timer_bank.sv =====
// Bank of periodic reload timers and one-shot timeouts.
// Requests: drive action_i, slot_i and count_value_i with start_i high; a request
// is taken at a rising edge where start_i is high and busy_o is low. busy_o is
// high only while the two-entry command queue is full.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i (0 is the
// number of period slots in use, 1 the number of timeout slots in use); the user
// must write only while the bank is idle, which the block itself does not enforce.
// Results: one per request, on accepted_o and the two masks for exactly one
// cycle while done_o is high; the receiver cannot stall and results are never
// held back.
// Order: a command result passes through the command queue, the report flag and
// the result registers; a tick sweeps all slots through the counter memories one per
// cycle, and its result then passes through the same report and result registers.
// Throughput: one command per cycle while the back end is idle; a tick holds the
// back end in its sweep over the memories while later requests wait in the queue.
// Reset: all timers are inactive, no done flags, all timeouts expired, and both
// in-use counts are 8. The counter memories need no clearing pass.
module periodic_and_timeout_timer_bank #(
  parameter int unsigned PERIOD_SLOTS  = ptb_pkg::PERIOD_SLOTS_DEF,
  parameter int unsigned TIMEOUT_SLOTS = ptb_pkg::TIMEOUT_SLOTS_DEF,
  parameter int unsigned COUNT_WIDTH   = ptb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptb_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [ptb_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            start_i,
  input  logic [ptb_pkg::ACTION_W-1:0]    action_i,
  input  logic [ptb_pkg::SLOT_W-1:0]      slot_i,
  input  logic [ptb_pkg::VALUE_W-1:0]     count_value_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic                            accepted_o,
  output logic [ptb_pkg::MASK_W-1:0]      period_done_mask_o,
  output logic [ptb_pkg::MASK_W-1:0]      timeout_expired_mask_o
);

  localparam int unsigned PCNT_W = $clog2(PERIOD_SLOTS + 1);
  localparam int unsigned TCNT_W = $clog2(TIMEOUT_SLOTS + 1);

  logic [ptb_pkg::CFG_W-1:0] p_cfg_q, p_cfg_d;
  logic [ptb_pkg::CFG_W-1:0] t_cfg_q, t_cfg_d;
  logic [PCNT_W-1:0]         p_in_use;
  logic [TCNT_W-1:0]         t_in_use;

  ptb_pkg::q_status_t q_status;
  ptb_pkg::cmd_t      push_cmd;
  ptb_pkg::cmd_t      head_cmd;
  logic               push;
  logic               pop;

  // Configuration registers.
  always_comb begin
    p_cfg_d = p_cfg_q;
    t_cfg_d = t_cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ptb_pkg::REG_PERIODS_IN_USE:  p_cfg_d = cfg_wdata_i;
        ptb_pkg::REG_TIMEOUTS_IN_USE: t_cfg_d = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_cfg_q <= ptb_pkg::IN_USE_RESET;
      t_cfg_q <= ptb_pkg::IN_USE_RESET;
    end else begin
      p_cfg_q <= p_cfg_d;
      t_cfg_q <= t_cfg_d;
    end
  end

  // In-use counts are limited to the number of slots built.
  assign p_in_use = (p_cfg_q > PERIOD_SLOTS) ? PCNT_W'(PERIOD_SLOTS) : PCNT_W'(p_cfg_q);
  assign t_in_use = (t_cfg_q > TIMEOUT_SLOTS) ? TCNT_W'(TIMEOUT_SLOTS) : TCNT_W'(t_cfg_q);

  ptb_front #(
    .PERIOD_SLOTS  (PERIOD_SLOTS),
    .TIMEOUT_SLOTS (TIMEOUT_SLOTS)
  ) u_front (
    .start_i       (start_i),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .count_value_i (count_value_i),
    .p_in_use_i    (p_in_use),
    .t_in_use_i    (t_in_use),
    .status_i      (q_status),
    .busy_o        (busy_o),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  ptb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_cmd),
    .pop_i    (pop),
    .data_o   (head_cmd),
    .status_o (q_status)
  );

  ptb_back #(
    .PERIOD_SLOTS  (PERIOD_SLOTS),
    .TIMEOUT_SLOTS (TIMEOUT_SLOTS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .q_empty_i              (q_status.empty),
    .cmd_i                  (head_cmd),
    .pop_o                  (pop),
    .p_in_use_i             (p_in_use),
    .t_in_use_i             (t_in_use),
    .done_o                 (done_o),
    .accepted_o             (accepted_o),
    .period_done_mask_o     (period_done_mask_o),
    .timeout_expired_mask_o (timeout_expired_mask_o)
  );

endmodule

// ===== tb/sv/periodic_and_timeout_timer_bank_test.sv =====
`timescale 1ns / 100ps

module periodic_and_timeout_timer_bank_test;

  // Action codes that the bank does not decode.
  localparam logic [ptb_pkg::ACTION_W-1:0] ACT_RSVD_A = 3'd6;
  localparam logic [ptb_pkg::ACTION_W-1:0] ACT_RSVD_B = 3'd7;

  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PHASE_ITEMS   = 215;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ptb_pkg::CFG_ADDR_W-1:0] cfg_addr_i;
  logic [ptb_pkg::CFG_W-1:0]      cfg_wdata_i;
  logic                           start_i;
  logic [ptb_pkg::ACTION_W-1:0]   action_i;
  logic [ptb_pkg::SLOT_W-1:0]     slot_i;
  logic [ptb_pkg::VALUE_W-1:0]    count_value_i;
  logic                           busy_o;
  logic                           done_o;
  logic                           accepted_o;
  logic [ptb_pkg::MASK_W-1:0]     period_done_mask_o;
  logic [ptb_pkg::MASK_W-1:0]     timeout_expired_mask_o;

  int unsigned sender_idle_pct;

  // Tracks the timer state of the bank and the status each request should report.
  class timer_bank_tracker;
    typedef struct packed {
      logic                       accepted;
      logic [ptb_pkg::MASK_W-1:0] done_mask;
      logic [ptb_pkg::MASK_W-1:0] expired_mask;
    } timer_status_t;

    bit [ptb_pkg::VALUE_W-1:0] period_count [ptb_pkg::PERIOD_SLOTS_DEF];
    bit [ptb_pkg::VALUE_W-1:0] period_reload [ptb_pkg::PERIOD_SLOTS_DEF];
    bit                        period_active [ptb_pkg::PERIOD_SLOTS_DEF];
    bit                        period_done [ptb_pkg::PERIOD_SLOTS_DEF];
    bit [ptb_pkg::VALUE_W-1:0] timeout_left [ptb_pkg::TIMEOUT_SLOTS_DEF];
    int unsigned               periods_in_use = int'(ptb_pkg::IN_USE_RESET);
    int unsigned               timeouts_in_use = int'(ptb_pkg::IN_USE_RESET);
    timer_status_t             awaited_status [$];
    int unsigned               faults;

    function void set_in_use(logic [ptb_pkg::CFG_ADDR_W-1:0] addr,
                             logic [ptb_pkg::CFG_W-1:0] value);
      if (addr == ptb_pkg::REG_PERIODS_IN_USE) begin
        periods_in_use = int'(value);
      end else begin
        timeouts_in_use = int'(value);
      end
    endfunction

    function int unsigned pending();
      return awaited_status.size();
    endfunction

    // Applies one accepted request and queues the status it must produce.
    function void take_request(logic [ptb_pkg::ACTION_W-1:0] act,
                               logic [ptb_pkg::SLOT_W-1:0] slot,
                               logic [ptb_pkg::VALUE_W-1:0] value);
      int unsigned   np;
      int unsigned   nt;
      bit            period_ok;
      bit            timeout_ok;
      timer_status_t status;
      np = (periods_in_use > ptb_pkg::PERIOD_SLOTS_DEF) ?
           ptb_pkg::PERIOD_SLOTS_DEF : periods_in_use;
      nt = (timeouts_in_use > ptb_pkg::TIMEOUT_SLOTS_DEF) ?
           ptb_pkg::TIMEOUT_SLOTS_DEF : timeouts_in_use;
      period_ok = slot < np;
      timeout_ok = slot < nt;
      status = '0;
      case (act)
        ptb_pkg::ACT_TICK: begin
          // Active period counters count down and reload when they hit zero.
          for (int i = 0; i < np; i++) begin
            if (period_active[i]) begin
              period_count[i] = period_count[i] - 1'b1;
              if (period_count[i] == '0) begin
                period_done[i] = 1'b1;
                period_count[i] = period_reload[i];
              end
            end
          end
          for (int i = 0; i < nt; i++) begin
            if (timeout_left[i] != '0) timeout_left[i] = timeout_left[i] - 1'b1;
          end
          status.accepted = 1'b1;
        end
        ptb_pkg::ACT_PSTART: if (period_ok) begin
          period_active[slot] = 1'b1;
          period_done[slot] = 1'b0;
          period_count[slot] = value;
          period_reload[slot] = value;
          status.accepted = 1'b1;
        end
        ptb_pkg::ACT_PSTOP: if (period_ok) begin
          period_active[slot] = 1'b0;
          status.accepted = 1'b1;
        end
        ptb_pkg::ACT_PCLEAR: if (period_ok) begin
          period_done[slot] = 1'b0;
          status.accepted = 1'b1;
        end
        ptb_pkg::ACT_TSTART: if (timeout_ok) begin
          timeout_left[slot] = value;
          status.accepted = 1'b1;
        end
        ptb_pkg::ACT_TSTOP: if (timeout_ok) begin
          timeout_left[slot] = '0;
          status.accepted = 1'b1;
        end
        default: begin
        end
      endcase
      // Masks reflect the state after the request, for slots in use only.
      for (int i = 0; i < np && i < ptb_pkg::MASK_W; i++) begin
        status.done_mask[i] = period_done[i];
      end
      for (int i = 0; i < nt && i < ptb_pkg::MASK_W; i++) begin
        status.expired_mask[i] = timeout_left[i] == '0;
      end
      awaited_status.push_back(status);
    endfunction

    function void report_mismatch(string field, logic [ptb_pkg::MASK_W-1:0] want,
                                  logic [ptb_pkg::MASK_W-1:0] got);
      faults++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    // Compares one result from the bank with the oldest outstanding status.
    function void match_result(logic acc, logic [ptb_pkg::MASK_W-1:0] pm,
                               logic [ptb_pkg::MASK_W-1:0] tm);
      timer_status_t want;
      if (awaited_status.size() == 0) begin
        faults++;
        $display("%0t: result with no request outstanding", $time);
        return;
      end
      want = awaited_status.pop_front();
      if (acc !== want.accepted) begin
        report_mismatch("accepted", {{(ptb_pkg::MASK_W-1){1'b0}}, want.accepted},
                        {{(ptb_pkg::MASK_W-1){1'b0}}, acc});
      end
      if (pm !== want.done_mask) report_mismatch("period_done_mask", want.done_mask, pm);
      if (tm !== want.expired_mask) begin
        report_mismatch("timeout_expired_mask", want.expired_mask, tm);
      end
    endfunction
  endclass

  timer_bank_tracker tracker = new();

  periodic_and_timeout_timer_bank dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_addr_i             (cfg_addr_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .start_i                (start_i),
    .action_i               (action_i),
    .slot_i                 (slot_i),
    .count_value_i          (count_value_i),
    .busy_o                 (busy_o),
    .done_o                 (done_o),
    .accepted_o             (accepted_o),
    .period_done_mask_o     (period_done_mask_o),
    .timeout_expired_mask_o (timeout_expired_mask_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Note each request the bank takes and check each result it strobes.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        tracker.take_request(action_i, slot_i, count_value_i);
      end
      if (done_o === 1'b1) begin
        tracker.match_result(accepted_o, period_done_mask_o, timeout_expired_mask_o);
      end
    end
  end

  // End the run if neither a request nor a result moves for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("periodic_and_timeout_timer_bank_test NOT OK");
    $finish;
  end

  // Presents one request, with an optional random gap first, and waits until it is taken.
  task automatic issue(input logic [ptb_pkg::ACTION_W-1:0] act,
                       input logic [ptb_pkg::SLOT_W-1:0] slot,
                       input logic [ptb_pkg::VALUE_W-1:0] val);
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start_i <= 1'b1;
    action_i <= act;
    slot_i <= slot;
    count_value_i <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Stops requesting and waits until every result is back and the bank is quiet.
  task automatic settle();
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both in-use counts on consecutive cycles.
  task automatic write_in_use(input logic [ptb_pkg::CFG_W-1:0] periods,
                              input logic [ptb_pkg::CFG_W-1:0] timeouts);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= ptb_pkg::REG_PERIODS_IN_USE;
    cfg_wdata_i <= periods;
    @(posedge clk_i);
    tracker.set_in_use(ptb_pkg::REG_PERIODS_IN_USE, periods);
    cfg_addr_i <= ptb_pkg::REG_TIMEOUTS_IN_USE;
    cfg_wdata_i <= timeouts;
    @(posedge clk_i);
    tracker.set_in_use(ptb_pkg::REG_TIMEOUTS_IN_USE, timeouts);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly short counts so that periods and timeouts actually run out.
  function automatic void draw_request(output logic [ptb_pkg::ACTION_W-1:0] act,
                                       output logic [ptb_pkg::SLOT_W-1:0] slot,
                                       output logic [ptb_pkg::VALUE_W-1:0] val);
    int unsigned roll;
    int unsigned shape;
    int unsigned pick_slot;
    int unsigned pick_val;
    roll = $urandom_range(99);
    shape = $urandom_range(9);
    pick_slot = $urandom_range(7);
    slot = pick_slot[ptb_pkg::SLOT_W-1:0];
    if (shape == 0) begin
      pick_val = 0;
    end else if (shape == 1) begin
      pick_val = $urandom;
    end else begin
      pick_val = $urandom_range(12, 1);
    end
    val = pick_val[ptb_pkg::VALUE_W-1:0];
    if (roll < 38) begin
      act = ptb_pkg::ACT_TICK;
    end else if (roll < 52) begin
      act = ptb_pkg::ACT_PSTART;
    end else if (roll < 60) begin
      act = ptb_pkg::ACT_PSTOP;
    end else if (roll < 68) begin
      act = ptb_pkg::ACT_PCLEAR;
    end else if (roll < 84) begin
      act = ptb_pkg::ACT_TSTART;
    end else if (roll < 94) begin
      act = ptb_pkg::ACT_TSTOP;
    end else begin
      act = $urandom_range(1) ? ACT_RSVD_B : ACT_RSVD_A;
    end
  endfunction

  initial begin : stimulus
    int unsigned                  periods_setting [6] = '{15, 3, 0, 8, 7, 1};
    int unsigned                  timeouts_setting [6] = '{2, 7, 15, 0, 6, 8};
    int unsigned                  sent;
    logic [ptb_pkg::ACTION_W-1:0] act;
    logic [ptb_pkg::SLOT_W-1:0]   slot;
    logic [ptb_pkg::VALUE_W-1:0]  val;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_addr_i <= ptb_pkg::REG_PERIODS_IN_USE;
    cfg_wdata_i <= '0;
    start_i <= 1'b0;
    action_i <= ptb_pkg::ACT_TICK;
    slot_i <= '0;
    count_value_i <= '0;
    sender_idle_pct = 7;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, one-tick periods, zero period, full-range counts,
    // restart, stop keeping the done flag, clear, and undecoded actions.
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_PSTART, 3'd0, 16'h0001);
    issue(ptb_pkg::ACT_PSTART, 3'd7, 16'hFFFF);
    issue(ptb_pkg::ACT_PSTART, 3'd1, 16'h0000);
    issue(ptb_pkg::ACT_TSTART, 3'd0, 16'h0002);
    issue(ptb_pkg::ACT_TSTART, 3'd7, 16'hFFFF);
    issue(ptb_pkg::ACT_TSTART, 3'd3, 16'h0000);
    issue(ptb_pkg::ACT_TICK, 3'd7, 16'hFFFF);
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_TICK, 3'd5, 16'h1234);
    issue(ptb_pkg::ACT_PCLEAR, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_PSTOP, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_PSTART, 3'd7, 16'h0002);
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_TSTOP, 3'd7, 16'h0000);
    issue(ACT_RSVD_A, 3'd5, 16'h5A5A);
    issue(ACT_RSVD_B, 3'd2, 16'hA5A5);
    issue(ptb_pkg::ACT_PSTOP, 3'd1, 16'h0000);
    issue(ptb_pkg::ACT_PSTART, 3'd2, 16'h0003);
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_TICK, 3'd0, 16'h0000);
    issue(ptb_pkg::ACT_PCLEAR, 3'd2, 16'h0000);
    settle();

    // Random phases, each under its own in-use counts and sender gap rate.
    for (int phase = 0; phase < 6; phase++) begin
      write_in_use(periods_setting[phase][ptb_pkg::CFG_W-1:0],
                   timeouts_setting[phase][ptb_pkg::CFG_W-1:0]);
      sender_idle_pct = (phase < 2) ? 7 : (phase < 4) ? 71 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        draw_request(act, slot, val);
        issue(act, slot, val);
        if (act <= ptb_pkg::ACT_TSTOP) sent++;
      end
      settle();
    end

    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("periodic_and_timeout_timer_bank_test OK");
    end else begin
      $display("periodic_and_timeout_timer_bank_test NOT OK");
    end
    $finish;
  end

endmodule
